// ===== rtl/prq_pkg.sv =====
// prq_pkg: shared types, codes and default sizes of the priority ready queue
// used by every module in rtl; depends on nothing
package prq_pkg;

    // field widths fixed by the interface
    localparam int OPC_W  = 2;
    localparam int TASK_W = 8;
    localparam int PRIO_W = 3;
    localparam int ERR_W  = 2;

    // default sizes handed to the top level parameters
    localparam int DEF_NUM_PRIORITIES = 8;
    localparam int DEF_LIST_DEPTH     = 8;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // opcode field encodings
    localparam logic [OPC_W-1:0] OPC_ADD    = 2'd0;
    localparam logic [OPC_W-1:0] OPC_REMOVE = 2'd1;
    localparam logic [OPC_W-1:0] OPC_QUERY  = 2'd2;

    // error field encodings
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

    // classified operation
    typedef enum logic [1:0] {
        OP_ADD,
        OP_REMOVE,
        OP_QUERY
    } t_op;

    // one classified request; a saturated level always fits the priority field
    typedef struct packed {
        t_op               op;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] level;
    } t_cmd;

    // queue status seen by front and back
    typedef struct packed {
        logic valid;
        logic full;
    } t_queue_status;

    // back end sequencer
    typedef enum logic {
        BK_WAIT,
        BK_READ
    } t_back_state;

endpackage

// ===== rtl/prq_front.sv =====
// prq_front: accepts requests and classifies them into queue commands
// depends on prq_pkg
module prq_front #(
    parameter int NUM_PRIORITIES = prq_pkg::DEF_NUM_PRIORITIES
) (
    input  logic                         start,
    input  logic [prq_pkg::OPC_W-1:0]    i_opcode,
    input  logic [prq_pkg::TASK_W-1:0]   i_task_id,
    input  logic [prq_pkg::PRIO_W-1:0]   i_task_priority,
    input  prq_pkg::t_queue_status       i_qstat,
    output logic                         o_push,
    output prq_pkg::t_cmd                o_cmd
);

    localparam int CMP_W = 7;

    logic [CMP_W-1:0] prio_ext;

    // request taken whenever the queue has room
    assign o_push = start & ~i_qstat.full;

    assign prio_ext = CMP_W'(i_task_priority);

    // decode opcode, unused code acts as a query; saturate priority to the top level
    always_comb begin
        o_cmd.task_id = i_task_id;
        case (i_opcode)
            prq_pkg::OPC_ADD:    o_cmd.op = prq_pkg::OP_ADD;
            prq_pkg::OPC_REMOVE: o_cmd.op = prq_pkg::OP_REMOVE;
            prq_pkg::OPC_QUERY:  o_cmd.op = prq_pkg::OP_QUERY;
            default:             o_cmd.op = prq_pkg::OP_QUERY;
        endcase
        if (prio_ext >= CMP_W'(NUM_PRIORITIES)) begin
            o_cmd.level = prq_pkg::PRIO_W'(NUM_PRIORITIES - 1);
        end else begin
            o_cmd.level = i_task_priority;
        end
    end

endmodule

// ===== rtl/prq_cmd_queue.sv =====
// prq_cmd_queue: short command queue that decouples front and back
// depends on prq_pkg
module prq_cmd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  prq_pkg::t_cmd          i_cmd,
    input  logic                   i_pop,
    output prq_pkg::t_cmd          o_cmd,
    output prq_pkg::t_queue_status o_qstat
);

    prq_pkg::t_cmd                 r_entry [prq_pkg::QUEUE_DEPTH];
    logic [prq_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [prq_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [prq_pkg::QCNT_W-1:0]    r_count;
    logic [prq_pkg::QPTR_W-1:0]    n_wr_ptr;
    logic [prq_pkg::QPTR_W-1:0]    n_rd_ptr;
    logic [prq_pkg::QCNT_W-1:0]    n_count;

    // status and head entry
    assign o_qstat = '{
        valid: (r_count != '0),
        full:  (r_count == prq_pkg::QCNT_W'(prq_pkg::QUEUE_DEPTH))
    };
    assign o_cmd   = r_entry[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == prq_pkg::QPTR_W'(prq_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == prq_pkg::QPTR_W'(prq_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/prq_back.sv =====
// prq_back: executes commands on the per-level fifos and reports the top task
// depends on prq_pkg
module prq_back #(
    parameter int NUM_PRIORITIES = prq_pkg::DEF_NUM_PRIORITIES,
    parameter int LIST_DEPTH     = prq_pkg::DEF_LIST_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  prq_pkg::t_cmd               i_cmd,
    input  prq_pkg::t_queue_status      i_qstat,
    output logic                        o_pop,
    output logic                        o_done,
    output logic [prq_pkg::TASK_W-1:0]  o_next_task,
    output logic                        o_found,
    output logic [prq_pkg::ERR_W-1:0]   o_error
);

    localparam int LW    = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int HW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW    = $clog2(LIST_DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int SLOTS = NUM_PRIORITIES * LIST_DEPTH;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    prq_pkg::t_back_state r_state;
    prq_pkg::t_back_state n_state;

    logic [prq_pkg::TASK_W-1:0] r_slots [SLOTS];
    logic [CW-1:0]              r_count [NUM_PRIORITIES];
    logic [HW-1:0]              r_head  [NUM_PRIORITIES];
    logic [prq_pkg::TASK_W-1:0] r_rd_data;
    logic                       r_found;
    logic                       r_done;
    logic [prq_pkg::ERR_W-1:0]  r_err;

    logic                       exec;
    logic [LW-1:0]              lvl;
    logic [LW-1:0]              pick;
    logic                       any_ready;
    logic [LW-1:0]              head_sel;
    logic [HW-1:0]              head_q;
    logic [CW-1:0]              cnt_q;
    logic [SW-1:0]              tail_sum;
    logic [SW-1:0]              head_sum;
    logic [HW-1:0]              tail_pos;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [CW-1:0]              n_count;
    logic [HW-1:0]              n_head;
    logic [prq_pkg::ERR_W-1:0]  n_err;

    // sequencer: execute a command, then read the top head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prq_pkg::BK_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        exec    = 1'b0;
        case (r_state)
            prq_pkg::BK_WAIT: begin
                if (i_qstat.valid) begin
                    exec    = 1'b1;
                    n_state = prq_pkg::BK_READ;
                end
            end
            prq_pkg::BK_READ: begin
                n_state = prq_pkg::BK_WAIT;
            end
            default: begin
                n_state = prq_pkg::BK_WAIT;
            end
        endcase
    end

    assign o_pop = exec;
    assign lvl   = LW'(i_cmd.level);

    // highest non-empty level, later levels win
    always_comb begin
        pick      = '0;
        any_ready = 1'b0;
        for (int p = 0; p < NUM_PRIORITIES; p++) begin
            if (r_count[p] != '0) begin
                pick      = LW'(p);
                any_ready = 1'b1;
            end
        end
    end

    // one read port on the head pointers, shared by both steps
    assign head_sel = (r_state == prq_pkg::BK_WAIT) ? lvl : pick;
    assign head_q   = r_head[head_sel];
    assign cnt_q    = r_count[lvl];

    // tail position and advanced head, wrapped to the depth
    always_comb begin
        tail_sum = SW'(head_q) + SW'(cnt_q);
        if (tail_sum >= SW'(LIST_DEPTH)) begin
            tail_sum = tail_sum - SW'(LIST_DEPTH);
        end
        head_sum = SW'(head_q) + SW'(1);
        if (head_sum >= SW'(LIST_DEPTH)) begin
            head_sum = head_sum - SW'(LIST_DEPTH);
        end
    end

    assign tail_pos = HW'(tail_sum);
    assign wr_addr  = AW'(int'(lvl) * LIST_DEPTH + int'(tail_pos));
    assign rd_addr  = AW'(int'(pick) * LIST_DEPTH + int'(head_q));

    // command execution
    always_comb begin
        wr_en   = 1'b0;
        n_count = cnt_q;
        n_head  = head_q;
        n_err   = prq_pkg::ERR_OK;
        case (i_cmd.op)
            prq_pkg::OP_ADD: begin
                if (cnt_q == CW'(LIST_DEPTH)) begin
                    n_err = prq_pkg::ERR_FULL;
                end else begin
                    wr_en   = exec;
                    n_count = cnt_q + 1'b1;
                end
            end
            prq_pkg::OP_REMOVE: begin
                if (cnt_q == '0) begin
                    n_err = prq_pkg::ERR_EMPTY;
                end else begin
                    n_count = cnt_q - 1'b1;
                    n_head  = HW'(head_sum);
                end
            end
            default: begin
                n_err = prq_pkg::ERR_OK;
            end
        endcase
    end

    // per-level pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PRIORITIES; p++) begin
                r_count[p] <= '0;
                r_head[p]  <= '0;
            end
        end else if (exec) begin
            r_count[lvl] <= n_count;
            r_head[lvl]  <= n_head;
        end
    end

    // task slot memory, registered read of the top head
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slots[wr_addr] <= i_cmd.task_id;
        end
        r_rd_data <= r_slots[rd_addr];
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_err   <= prq_pkg::ERR_OK;
        end else begin
            r_done <= (r_state == prq_pkg::BK_READ);
            if (exec) begin
                r_err <= n_err;
            end
            if (r_state == prq_pkg::BK_READ) begin
                r_found <= any_ready;
            end
        end
    end

    assign o_done      = r_done;
    assign o_found     = r_found;
    assign o_error     = r_err;
    assign o_next_task = r_found ? r_rd_data : '0;

endmodule

// ===== rtl/priority_ready_queue.sv =====
// priority_ready_queue: ready queue with one circular fifo per priority level
// the result strobe o_done follows the command queue, the execute step and the slot read step
// the back end takes the next command only after the execute and slot read steps of the last one
// busy rises while the two-entry command queue is full; results cannot be stalled
// reset: synchronous active-low i_rst_n empties every fifo and the command queue
// depends on prq_pkg, prq_front, prq_cmd_queue, prq_back
module priority_ready_queue #(
    parameter int NUM_PRIORITIES = prq_pkg::DEF_NUM_PRIORITIES,
    parameter int LIST_DEPTH     = prq_pkg::DEF_LIST_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [prq_pkg::OPC_W-1:0]   i_opcode,
    input  logic [prq_pkg::TASK_W-1:0]  i_task_id,
    input  logic [prq_pkg::PRIO_W-1:0]  i_task_priority,
    output logic                        o_done,
    output logic [prq_pkg::TASK_W-1:0]  o_next_task,
    output logic                        o_found,
    output logic [prq_pkg::ERR_W-1:0]   o_error
);

    prq_pkg::t_cmd          front_cmd;
    prq_pkg::t_cmd          head_cmd;
    prq_pkg::t_queue_status qstat;
    logic                   push;
    logic                   pop;

    assign busy = qstat.full;

    // request intake and classification
    prq_front #(
        .NUM_PRIORITIES (NUM_PRIORITIES)
    ) u_front (
        .start           (start),
        .i_opcode        (i_opcode),
        .i_task_id       (i_task_id),
        .i_task_priority (i_task_priority),
        .i_qstat         (qstat),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    // command queue
    prq_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_qstat (qstat)
    );

    // fifo execution and top task lookup
    prq_back #(
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .LIST_DEPTH     (LIST_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_done      (o_done),
        .o_next_task (o_next_task),
        .o_found     (o_found),
        .o_error     (o_error)
    );

endmodule
